// File: sv/cpd_pkg.sv
// Shared constants, codes and types of the coin payment and change dispenser.
package cpd_pkg;

    // Field widths of the transfer payloads.
    localparam int FUNC_W  = 3;
    localparam int STAT_W  = 3;
    localparam int CNT_W   = 16;
    localparam int CHG_W   = 10;

    // Denomination list, largest first; the chain holds one cell per entry in use.
    localparam int MAX_DENOMS     = 8;
    localparam int NUM_DENOMS_DEF = 8;

    typedef logic [CHG_W-1:0] t_denom_arr [MAX_DENOMS];

    localparam t_denom_arr DENOM_VALUE = '{
        10'd1000, 10'd500, 10'd200, 10'd100, 10'd50, 10'd20, 10'd10, 10'd5
    };

    localparam logic [CNT_W-1:0] CNT_MAX           = '1;
    localparam logic [CNT_W-1:0] DEFAULT_COUNT_RST = 16'd20;

    // Operation codes of an input item.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_START       = 3'd0,
        FUNC_COIN        = 3'd1,
        FUNC_CANCEL      = 3'd2,
        FUNC_RESET_COINS = 3'd3,
        FUNC_LOAD        = 3'd4
    } t_func;

    // Status codes of a result item.
    typedef enum logic [STAT_W-1:0] {
        STAT_OWING       = 3'd0,
        STAT_INVALID     = 3'd1,
        STAT_SOLD_EXACT  = 3'd2,
        STAT_SOLD_CHANGE = 3'd3,
        STAT_REFUND_FAIL = 3'd4,
        STAT_CANCELLED   = 3'd5,
        STAT_DONE        = 3'd6,
        STAT_IGNORED     = 3'd7
    } t_status;

    // Command broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic             clear_recv;
        logic             count_coin;
        logic             reset_held;
        logic             load_hit;
        logic             load_miss;
        logic             commit;
        logic [CNT_W-1:0] default_count;
        logic [CNT_W-1:0] load_count;
    } t_cell_cmd;

    // Result item as held in the output register.
    typedef struct packed {
        logic [STAT_W-1:0]                 status;
        logic [CNT_W-1:0]                  owing;
        logic [CHG_W-1:0]                  change;
        logic [MAX_DENOMS-1:0][CNT_W-1:0]  handed;
    } t_rsp;

endpackage

// File: sv/cpd_if.sv
// Channel interfaces of the dispenser: request, response and configuration write.
interface cpd_req_if import cpd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [CNT_W-1:0]  price_cents;
    logic [CNT_W-1:0]  coin_cents;
    logic [CNT_W-1:0]  load_count;

    modport source (output valid, func, price_cents, coin_cents, load_count, input ready);
    modport sink   (input valid, func, price_cents, coin_cents, load_count, output ready);
endinterface

interface cpd_rsp_if import cpd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  owing_cents;
    logic [CHG_W-1:0]  change_cents;
    logic [CNT_W-1:0]  out_1000;
    logic [CNT_W-1:0]  out_500;
    logic [CNT_W-1:0]  out_200;
    logic [CNT_W-1:0]  out_100;
    logic [CNT_W-1:0]  out_50;
    logic [CNT_W-1:0]  out_20;
    logic [CNT_W-1:0]  out_10;
    logic [CNT_W-1:0]  out_5;

    modport source (output valid, status, owing_cents, change_cents, out_1000, out_500,
                    out_200, out_100, out_50, out_20, out_10, out_5, input ready);
    modport sink   (input valid, status, owing_cents, change_cents, out_1000, out_500,
                    out_200, out_100, out_50, out_20, out_10, out_5, output ready);
endinterface

interface cpd_cfg_if import cpd_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: sv/cpd_cell.sv
// One denomination cell: held and received counts plus one greedy change step.
module cpd_cell import cpd_pkg::*; #(
    parameter logic [CHG_W-1:0] Denom  = 10'd5,
    parameter bit               IsLast = 1'b0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_cmd        i_cmd,
    input  logic [CNT_W-1:0] i_coin,
    input  logic             i_go,
    input  logic [CHG_W-1:0] i_rem,
    output logic             o_go,
    output logic [CHG_W-1:0] o_rem,
    output logic             o_hit,
    output logic [CNT_W-1:0] o_received,
    output logic [CHG_W-1:0] o_given
);

    // Division by the denomination as a multiplication by a scaled reciprocal.
    localparam int               RecipShift = 24;
    localparam int               ProdW      = RecipShift + CHG_W;
    localparam logic [ProdW-1:0] Recip      =
        ProdW'(((64'd1 << RecipShift) + 64'(Denom) - 64'd1) / 64'(Denom));

    logic [CNT_W-1:0] r_held, n_held;
    logic [CNT_W-1:0] r_recv, n_recv;
    logic [CHG_W-1:0] r_given;
    logic [CHG_W-1:0] r_rem1;
    logic             r_go1;
    logic [CHG_W-1:0] r_rem2;
    logic             r_go2;

    logic [CNT_W:0]     w_sum;
    logic [CNT_W-1:0]   w_trial;
    logic [ProdW-1:0]   w_prod;
    logic [CHG_W-1:0]   w_quot;
    logic [CHG_W-1:0]   w_take;
    logic [2*CHG_W-1:0] w_paid;

    assign o_hit      = (i_coin == {{(CNT_W-CHG_W){1'b0}}, Denom});
    assign o_received = r_recv;
    assign o_given    = r_given;
    assign o_go       = r_go2;
    assign o_rem      = r_rem2;

    // Coins available for change: held plus received, saturated.
    assign w_sum   = {1'b0, r_held} + {1'b0, r_recv};
    assign w_trial = w_sum[CNT_W] ? CNT_MAX : w_sum[CNT_W-1:0];

    // First step: coins of this value wanted, limited by what is available.
    assign w_prod = {{RecipShift{1'b0}}, i_rem} * Recip;
    assign w_quot = w_prod[ProdW-1:RecipShift];
    assign w_take = ({{(CNT_W-CHG_W){1'b0}}, w_quot} > w_trial) ? w_trial[CHG_W-1:0]
                                                                 : w_quot;

    // Second step: value of the coins taken.
    assign w_paid = {{CHG_W{1'b0}}, r_given} * {{CHG_W{1'b0}}, Denom};

    // Count updates ordered by the controller's command.
    always_comb begin
        n_held = r_held;
        n_recv = r_recv;
        if (i_cmd.reset_held) begin
            n_held = i_cmd.default_count;
        end else if ((i_cmd.load_hit && o_hit) || (i_cmd.load_miss && IsLast)) begin
            n_held = i_cmd.load_count;
        end else if (i_cmd.commit) begin
            n_held = w_trial - {{(CNT_W-CHG_W){1'b0}}, r_given};
        end
        if (i_cmd.clear_recv) begin
            n_recv = '0;
        end else if (i_cmd.count_coin && o_hit && (r_recv != CNT_MAX)) begin
            n_recv = r_recv + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_recv <= '0;
            r_go1  <= 1'b0;
            r_go2  <= 1'b0;
        end else begin
            r_held <= n_held;
            r_recv <= n_recv;
            r_go1  <= i_go;
            r_go2  <= r_go1;
        end
    end

    // Remainder pipeline handed on to the next smaller denomination.
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_given <= w_take;
        end
        r_rem1 <= i_rem;
        r_rem2 <= r_rem1 - w_paid[CHG_W-1:0];
    end

endmodule

// File: sv/coin_payment_and_change_dispenser_core.sv
// Top level of the coin payment and change dispenser: controller and cell chain.
// Items are taken one at a time. Start, cancel, reset-coins, load, an invalid or
// ignored item and a coin that leaves an amount owing all have their result loaded
// into the output register at the transfer. A coin that meets the amount owed starts
// the greedy change search: the remainder walks the chain of denomination cells, two
// registered steps per cell (reciprocal multiply and clamp, then subtract), and its
// result is loaded once the remainder has left the smallest cell. A new item is taken
// once the controller is idle and the output register is empty or being emptied in
// the same cycle.
module coin_payment_and_change_dispenser_core import cpd_pkg::*; #(
    parameter int NUM_DENOMS = NUM_DENOMS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cpd_req_if.sink   i_req,
    cpd_rsp_if.source o_rsp,
    cpd_cfg_if.sink   i_cfg
);

    localparam int DenUsed = (NUM_DENOMS < MAX_DENOMS) ? NUM_DENOMS : MAX_DENOMS;

    typedef enum logic {
        ST_IDLE,
        ST_CHANGE
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_default;
    logic [CNT_W-1:0] r_owed, n_owed;
    logic             r_in_purchase, n_in_purchase;
    logic [CHG_W-1:0] r_change, n_change;
    logic             r_start, n_start;
    logic             r_out_valid, n_out_valid;
    t_rsp             r_out, n_out;

    t_cell_cmd        w_cmd;
    t_rsp             w_res;
    logic             w_load_res;
    logic             w_accept;
    logic             w_any_hit;
    logic             w_recv_any;
    logic [CHG_W-1:0] w_coin_val;
    logic [CNT_W-1:0] w_coin16;

    logic             w_go   [DenUsed+1];
    logic [CHG_W-1:0] w_rem  [DenUsed+1];
    logic             w_hit  [DenUsed];
    logic [CNT_W-1:0] w_recv [DenUsed];
    logic [CHG_W-1:0] w_given[DenUsed];

    // Chain of denomination cells, largest first.
    assign w_go[0]  = r_start;
    assign w_rem[0] = r_change;

    for (genvar g = 0; g < DenUsed; g++) begin : g_cell
        cpd_cell #(
            .Denom  (DENOM_VALUE[g]),
            .IsLast (g == DenUsed - 1)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (w_cmd),
            .i_coin     (i_req.coin_cents),
            .i_go       (w_go[g]),
            .i_rem      (w_rem[g]),
            .o_go       (w_go[g+1]),
            .o_rem      (w_rem[g+1]),
            .o_hit      (w_hit[g]),
            .o_received (w_recv[g]),
            .o_given    (w_given[g])
        );
    end

    // Coin recognition from the cells' match flags.
    always_comb begin
        w_any_hit  = 1'b0;
        w_coin_val = '0;
        w_recv_any = 1'b0;
        for (int k = 0; k < DenUsed; k++) begin
            w_any_hit  = w_any_hit | w_hit[k];
            w_coin_val = w_coin_val | (w_hit[k] ? DENOM_VALUE[k] : '0);
            w_recv_any = w_recv_any | (w_recv[k] != '0);
        end
    end

    assign w_coin16 = {{(CNT_W-CHG_W){1'b0}}, w_coin_val};

    // Handshakes.
    assign i_req.ready = (r_state == ST_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    // Item decode, cell commands and next state.
    always_comb begin
        n_state       = r_state;
        n_owed        = r_owed;
        n_in_purchase = r_in_purchase;
        n_change      = r_change;
        n_start       = 1'b0;
        n_out_valid   = r_out_valid;
        n_out         = r_out;

        w_cmd               = '0;
        w_cmd.default_count = r_default;
        w_cmd.load_count    = i_req.load_count;

        w_load_res    = 1'b0;
        w_res         = '0;
        w_res.status  = STAT_IGNORED;
        w_res.owing   = r_owed;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        if (w_accept) begin
            w_load_res = 1'b1;
            case (i_req.func)
                FUNC_START: begin
                    if (!r_in_purchase) begin
                        if (i_req.price_cents == '0) begin
                            w_res.status = STAT_SOLD_EXACT;
                        end else begin
                            w_cmd.clear_recv = 1'b1;
                            n_owed           = i_req.price_cents;
                            n_in_purchase    = 1'b1;
                            w_res.status     = STAT_OWING;
                            w_res.owing      = i_req.price_cents;
                        end
                    end
                end
                FUNC_COIN: begin
                    if (r_in_purchase) begin
                        if (!w_any_hit) begin
                            w_res.status = STAT_INVALID;
                        end else begin
                            w_cmd.count_coin = 1'b1;
                            if (w_coin16 < r_owed) begin
                                n_owed       = r_owed - w_coin16;
                                w_res.status = STAT_OWING;
                                w_res.owing  = r_owed - w_coin16;
                            end else begin
                                n_change   = CHG_W'(w_coin16 - r_owed);
                                n_start    = 1'b1;
                                n_state    = ST_CHANGE;
                                w_load_res = 1'b0;
                            end
                        end
                    end
                end
                FUNC_CANCEL: begin
                    if (r_in_purchase) begin
                        for (int k = 0; k < DenUsed; k++) begin
                            w_res.handed[k] = w_recv[k];
                        end
                        w_cmd.clear_recv = 1'b1;
                        n_owed           = '0;
                        n_in_purchase    = 1'b0;
                        w_res.status     = STAT_CANCELLED;
                        w_res.owing      = '0;
                    end
                end
                FUNC_RESET_COINS: begin
                    w_cmd.reset_held = 1'b1;
                    w_res.status     = STAT_DONE;
                end
                FUNC_LOAD: begin
                    w_cmd.load_hit  = w_any_hit;
                    w_cmd.load_miss = !w_any_hit;
                    w_res.status    = STAT_DONE;
                end
                default: begin
                    w_res.status = STAT_IGNORED;
                end
            endcase
        end else if ((r_state == ST_CHANGE) && w_go[DenUsed]) begin
            // The remainder has left the smallest cell: close the purchase.
            w_load_res       = 1'b1;
            n_state          = ST_IDLE;
            w_cmd.clear_recv = 1'b1;
            n_owed           = '0;
            n_in_purchase    = 1'b0;
            w_res.owing      = '0;
            if (w_rem[DenUsed] == '0) begin
                w_cmd.commit = 1'b1;
                for (int k = 0; k < DenUsed; k++) begin
                    w_res.handed[k] = {{(CNT_W-CHG_W){1'b0}}, w_given[k]};
                end
                w_res.change = r_change;
                w_res.status = (r_change == '0) ? STAT_SOLD_EXACT : STAT_SOLD_CHANGE;
            end else begin
                for (int k = 0; k < DenUsed; k++) begin
                    w_res.handed[k] = w_recv[k];
                end
                w_res.status = STAT_REFUND_FAIL;
            end
        end

        if (w_load_res) begin
            n_out_valid = 1'b1;
            n_out       = w_res;
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_default     <= DEFAULT_COUNT_RST;
            r_owed        <= '0;
            r_in_purchase <= 1'b0;
            r_start       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_owed        <= n_owed;
            r_in_purchase <= n_in_purchase;
            r_start       <= n_start;
            r_out_valid   <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_default <= i_cfg.data;
            end
        end
        r_change <= n_change;
        r_out    <= n_out;
    end

    // Response port.
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.owing_cents  = r_out.owing;
    assign o_rsp.change_cents = r_out.change;
    assign o_rsp.out_1000     = r_out.handed[0];
    assign o_rsp.out_500      = r_out.handed[1];
    assign o_rsp.out_200      = r_out.handed[2];
    assign o_rsp.out_100      = r_out.handed[3];
    assign o_rsp.out_50       = r_out.handed[4];
    assign o_rsp.out_20       = r_out.handed[5];
    assign o_rsp.out_10       = r_out.handed[6];
    assign o_rsp.out_5        = r_out.handed[7];

    // The change remainder never leaves the chain while the controller is idle.
    a_no_stray_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_go[DenUsed])
        else $error("change remainder left the chain while idle");

    // An open purchase always owes a nonzero amount.
    a_owed_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_purchase |-> (r_owed != '0))
        else $error("open purchase with nothing owed");

    // Received coins are only held while a purchase is open.
    a_recv_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_purchase |-> !w_recv_any)
        else $error("received coins held with no open purchase");

    // A sale with change always reports a nonzero change amount.
    a_change_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == STAT_SOLD_CHANGE)) |-> (r_out.change != '0))
        else $error("sold with change but no change given");

    // Starting a change search always ends the transfer cycle in the change state.
    a_start_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> (r_state == ST_CHANGE))
        else $error("change search started outside the change state");

endmodule

// File: test/coin_payment_and_change_dispenser_core_test.sv
// Self-checking testbench of the coin payment and change dispenser core.
module coin_payment_and_change_dispenser_core_test;
    import cpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DENOMS_USED  = NUM_DENOMS_DEF < MAX_DENOMS ? NUM_DENOMS_DEF : MAX_DENOMS;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 270;
    localparam int SETTLE_CYC   = 24;
    localparam int HOLD_CYC     = 300;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int REPORT_MAX   = 10;
    localparam int SCRIPT_ROWS  = 25;

    // Operation codes that the block does not define.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CNT_W-1:0]  price;
        logic [CNT_W-1:0]  coin;
        logic [CNT_W-1:0]  count;
    } t_order;

    // Coin slot 0 is the 1000-cent coin, slot 7 the 5-cent coin.
    typedef struct packed {
        t_status                          status;
        logic [CNT_W-1:0]                 owing;
        logic [CHG_W-1:0]                 change;
        logic [MAX_DENOMS-1:0][CNT_W-1:0] coins;
    } t_payout;

    typedef struct packed {
        t_order           ord;
        bit               typed;
        t_status          status;
        logic [CNT_W-1:0] owing;
    } t_script_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cpd_req_if req_ch ();
    cpd_rsp_if rsp_ch ();
    cpd_cfg_if cfg_ch ();

    coin_payment_and_change_dispenser_core #(
        .NUM_DENOMS (NUM_DENOMS_DEF)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    // Predicted machine state.
    logic [CNT_W-1:0] held_count [MAX_DENOMS];
    logic [CNT_W-1:0] recv_count [MAX_DENOMS];
    logic [CNT_W-1:0] owed_cents;
    logic             purchase_open;
    logic [CNT_W-1:0] refill_count;

    t_payout pending_payouts [$];
    int      items_sent   = 0;
    int      mismatches   = 0;
    int      cycle_count  = 0;
    bit      steady_flow  = 1'b0;
    bit      hold_rsp     = 1'b0;

    // Directed items; typed rows carry an expectation that is obvious by inspection.
    t_script_row script [SCRIPT_ROWS] = '{
        '{'{FUNC_COIN,        16'd0,     16'd1000,  16'd0},     1'b1, STAT_IGNORED,    16'd0},
        '{'{FUNC_CANCEL,      16'd0,     16'd0,     16'd0},     1'b1, STAT_IGNORED,    16'd0},
        '{'{FUNC_START,       16'd0,     16'd0,     16'd0},     1'b1, STAT_SOLD_EXACT, 16'd0},
        '{'{FUNC_UNUSED_LO,   16'd0,     16'd0,     16'd0},     1'b1, STAT_IGNORED,    16'd0},
        '{'{FUNC_UNUSED_HI,   16'hffff,  16'hffff,  16'hffff},  1'b1, STAT_IGNORED,    16'd0},
        '{'{FUNC_RESET_COINS, 16'd0,     16'd0,     16'd0},     1'b1, STAT_DONE,       16'd0},
        '{'{FUNC_START,       16'd65535, 16'd0,     16'd0},     1'b1, STAT_OWING,  16'd65535},
        '{'{FUNC_START,       16'd100,   16'd0,     16'd0},     1'b1, STAT_IGNORED, 16'd65535},
        '{'{FUNC_COIN,        16'd0,     16'd0,     16'd0},     1'b1, STAT_INVALID, 16'd65535},
        '{'{FUNC_COIN,        16'd0,     16'd1000,  16'd0},     1'b1, STAT_OWING,  16'd64535},
        '{'{FUNC_CANCEL,      16'd0,     16'd0,     16'd0},     1'b0, STAT_CANCELLED,  16'd0},
        '{'{FUNC_START,       16'd35,    16'd0,     16'd0},     1'b1, STAT_OWING,      16'd35},
        '{'{FUNC_COIN,        16'd0,     16'd50,    16'd0},     1'b0, STAT_SOLD_CHANGE, 16'd0},
        '{'{FUNC_START,       16'd5,     16'd0,     16'd0},     1'b1, STAT_OWING,      16'd5},
        '{'{FUNC_COIN,        16'd0,     16'd1000,  16'd0},     1'b0, STAT_SOLD_CHANGE, 16'd0},
        '{'{FUNC_LOAD,        16'd0,     16'd10,    16'd0},     1'b1, STAT_DONE,       16'd0},
        '{'{FUNC_LOAD,        16'd0,     16'd5,     16'd0},     1'b1, STAT_DONE,       16'd0},
        '{'{FUNC_START,       16'd15,    16'd0,     16'd0},     1'b1, STAT_OWING,      16'd15},
        '{'{FUNC_COIN,        16'd0,     16'd20,    16'd0},     1'b0, STAT_REFUND_FAIL, 16'd0},
        '{'{FUNC_LOAD,        16'd0,     16'd3,     16'd65535}, 1'b1, STAT_DONE,       16'd0},
        '{'{FUNC_LOAD,        16'd0,     16'd1000,  16'd65535}, 1'b1, STAT_DONE,       16'd0},
        '{'{FUNC_START,       16'd1000,  16'd0,     16'd0},     1'b1, STAT_OWING,      16'd1000},
        '{'{FUNC_COIN,        16'd0,     16'd1000,  16'd0},     1'b1, STAT_SOLD_EXACT, 16'd0},
        '{'{FUNC_START,       16'd1,     16'd0,     16'd0},     1'b1, STAT_OWING,      16'd1},
        '{'{FUNC_COIN,        16'd0,     16'd1000,  16'd0},     1'b0, STAT_REFUND_FAIL, 16'd0}
    };

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Returns the coin slot of a value, or -1 when the value is not a coin in use.
    function automatic int coin_slot(input logic [CNT_W-1:0] value);
        for (int i = 0; i < DENOMS_USED; i++) begin
            if (int'(value) == int'(DENOM_VALUE[i])) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void close_purchase();
        for (int i = 0; i < MAX_DENOMS; i++) begin
            recv_count[i] = '0;
        end
        owed_cents    = '0;
        purchase_open = 1'b0;
    endfunction

    // Applies one accepted item to the predicted state and returns its result.
    function automatic t_payout vend_outcome(input t_order it);
        t_payout          res;
        logic [CNT_W-1:0] trial [MAX_DENOMS];
        int               slot;
        int               value;
        int               change;
        int               rem;
        int               n;
        int               sum;

        res        = '0;
        res.status = STAT_IGNORED;
        case (it.func)
            FUNC_START: begin
                if (!purchase_open) begin
                    if (it.price == 0) begin
                        res.status = STAT_SOLD_EXACT;
                    end else begin
                        close_purchase();
                        owed_cents    = it.price;
                        purchase_open = 1'b1;
                        res.status    = STAT_OWING;
                    end
                end
            end
            FUNC_COIN: begin
                if (purchase_open) begin
                    slot = coin_slot(it.coin);
                    if (slot < 0) begin
                        res.status = STAT_INVALID;
                    end else begin
                        value = int'(DENOM_VALUE[slot]);
                        if (recv_count[slot] != CNT_MAX) begin
                            recv_count[slot] = recv_count[slot] + CNT_W'(1);
                        end
                        if (value < int'(owed_cents)) begin
                            owed_cents = owed_cents - CNT_W'(value);
                            res.status = STAT_OWING;
                        end else begin
                            // Greedy change over held plus received coins.
                            change = value - int'(owed_cents);
                            rem    = change;
                            for (int i = 0; i < DENOMS_USED; i++) begin
                                sum      = int'(held_count[i]) + int'(recv_count[i]);
                                trial[i] = sum > int'(CNT_MAX) ? CNT_MAX : CNT_W'(sum);
                                n        = rem / int'(DENOM_VALUE[i]);
                                if (n > int'(trial[i])) begin
                                    n = int'(trial[i]);
                                end
                                res.coins[i] = CNT_W'(n);
                                rem          = rem - n * int'(DENOM_VALUE[i]);
                            end
                            if (rem != 0) begin
                                // No exact change: the received coins go back.
                                for (int i = 0; i < DENOMS_USED; i++) begin
                                    res.coins[i] = recv_count[i];
                                end
                                res.status = STAT_REFUND_FAIL;
                            end else begin
                                for (int i = 0; i < DENOMS_USED; i++) begin
                                    held_count[i] = trial[i] - res.coins[i];
                                end
                                res.change = CHG_W'(change);
                                res.status = change == 0 ? STAT_SOLD_EXACT : STAT_SOLD_CHANGE;
                            end
                            close_purchase();
                        end
                    end
                end
            end
            FUNC_CANCEL: begin
                if (purchase_open) begin
                    for (int i = 0; i < DENOMS_USED; i++) begin
                        res.coins[i] = recv_count[i];
                    end
                    close_purchase();
                    res.status = STAT_CANCELLED;
                end
            end
            FUNC_RESET_COINS: begin
                for (int i = 0; i < DENOMS_USED; i++) begin
                    held_count[i] = refill_count;
                end
                res.status = STAT_DONE;
            end
            FUNC_LOAD: begin
                slot = coin_slot(it.coin);
                if (slot < 0) begin
                    slot = DENOMS_USED - 1;
                end
                held_count[slot] = it.count;
                res.status       = STAT_DONE;
            end
            default: begin
            end
        endcase
        res.owing = owed_cents;
        return res;
    endfunction

    // Idle length for either side: mostly short, a few long, none in steady stretches.
    function automatic int pick_gap();
        int r;

        r = $urandom_range(0, 99);
        if (steady_flow || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    // Offers one item, waits for its transfer and records the expected result.
    task automatic push_order(input t_order it, input bit typed, input t_payout typed_exp);
        t_payout pred;
        int      gap;

        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.func        <= it.func;
        req_ch.price_cents <= it.price;
        req_ch.coin_cents  <= it.coin;
        req_ch.load_count  <= it.count;
        do @(posedge i_clk); while (!req_ch.ready);
        pred = vend_outcome(it);
        pending_payouts.insert(pending_payouts.size(), typed ? typed_exp : pred);
        if (pred.status != STAT_IGNORED) begin
            items_sent++;
        end
    endtask

    // Stops offering and waits until every expected result has been seen.
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_payouts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_refill(input logic [CNT_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        refill_count = value;
    endtask

    function automatic logic [CNT_W-1:0] pick_coin();
        if ($urandom_range(0, 99) < 88) begin
            return CNT_W'(DENOM_VALUE[$urandom_range(0, DENOMS_USED - 1)]);
        end
        return CNT_W'($urandom);
    endfunction

    function automatic logic [CNT_W-1:0] pick_stock();
        int r;

        r = $urandom_range(0, 99);
        if (r < 40) return CNT_W'($urandom_range(0, 3));
        if (r < 55) return CNT_MAX;
        if (r < 65) return '0;
        return CNT_W'($urandom);
    endfunction

    function automatic t_order pick_refill_or_load();
        t_order it;

        it       = '0;
        it.price = CNT_W'($urandom);
        if ($urandom_range(0, 2) == 0) begin
            it.func = FUNC_RESET_COINS;
            it.coin = CNT_W'($urandom);
        end else begin
            it.func  = FUNC_LOAD;
            it.coin  = pick_coin();
            it.count = pick_stock();
        end
        return it;
    endfunction

    // One random group: noise, a stock change, or a whole purchase with random content.
    task automatic random_group();
        t_order it;
        int     r;
        int     coins;

        if ($urandom_range(0, 39) == 0) begin
            steady_flow = !steady_flow;
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
            it.func  = FUNC_W'($urandom_range(0, 7));
            it.price = CNT_W'($urandom);
            it.coin  = CNT_W'($urandom);
            it.count = CNT_W'($urandom);
            push_order(it, 1'b0, '0);
        end else if (r < 22) begin
            push_order(pick_refill_or_load(), 1'b0, '0);
        end else begin
            it       = '0;
            it.func  = FUNC_START;
            it.coin  = CNT_W'($urandom);
            it.count = CNT_W'($urandom);
            r        = $urandom_range(0, 99);
            if (r < 80) begin
                it.price = CNT_W'(5 * $urandom_range(1, 300));
            end else if (r < 92) begin
                it.price = CNT_W'($urandom_range(1, 3000));
            end else if (r < 97) begin
                it.price = CNT_W'($urandom_range(1, 65535));
            end else begin
                it.price = '0;
            end
            push_order(it, 1'b0, '0);
            coins = 0;
            while (purchase_open) begin
                r        = $urandom_range(0, 99);
                it       = '0;
                it.price = CNT_W'($urandom);
                if (coins > 100 || r < 4) begin
                    it.func = FUNC_CANCEL;
                end else if (r < 6) begin
                    it.func = FUNC_START;
                end else if (r < 9) begin
                    it = pick_refill_or_load();
                end else begin
                    it.func  = FUNC_COIN;
                    it.coin  = pick_coin();
                    it.count = CNT_W'($urandom);
                end
                push_order(it, 1'b0, '0);
                coins++;
            end
        end
    endtask

    // Result side: random stalls, and one long hold-off when asked for.
    initial begin
        int gap;

        rsp_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = hold_rsp ? HOLD_CYC : pick_gap();
            hold_rsp = 1'b0;
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Compare every result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_payout got;
        t_payout want;
        bit      bad;

        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.status   = t_status'(rsp_ch.status);
            got.owing    = rsp_ch.owing_cents;
            got.change   = rsp_ch.change_cents;
            got.coins[0] = rsp_ch.out_1000;
            got.coins[1] = rsp_ch.out_500;
            got.coins[2] = rsp_ch.out_200;
            got.coins[3] = rsp_ch.out_100;
            got.coins[4] = rsp_ch.out_50;
            got.coins[5] = rsp_ch.out_20;
            got.coins[6] = rsp_ch.out_10;
            got.coins[7] = rsp_ch.out_5;
            if (pending_payouts.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("%0t: unexpected result, status %0d owing %0d",
                             $realtime, got.status, got.owing);
                end
            end else begin
                want = pending_payouts.pop_front();
                bad  = got.status !== want.status || got.owing !== want.owing ||
                       got.change !== want.change;
                for (int i = 0; i < MAX_DENOMS; i++) begin
                    if (got.coins[i] !== want.coins[i]) begin
                        bad = 1'b1;
                    end
                end
                if (bad) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("%0t: mismatch, expected status %0d owing %0d change %0d coins %h",
                                 $realtime, want.status, want.owing, want.change, want.coins);
                        $display("%0t:           actual status %0d owing %0d change %0d coins %h",
                                 $realtime, got.status, got.owing, got.change, got.coins);
                    end
                end
            end
        end
    end

    // Main sequence: reset, directed items, then random phases over several refill counts.
    initial begin
        t_payout typed_exp;

        i_rst_n            <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.func        <= '0;
        req_ch.price_cents <= '0;
        req_ch.coin_cents  <= '0;
        req_ch.load_count  <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.data        <= '0;
        for (int i = 0; i < MAX_DENOMS; i++) begin
            held_count[i] = '0;
        end
        close_purchase();
        refill_count = DEFAULT_COUNT_RST;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                drain();
                case (phase)
                    1:       write_refill('0);
                    2:       write_refill(CNT_MAX);
                    3:       write_refill(CNT_W'($urandom));
                    default: write_refill(CNT_W'($urandom_range(1, 5)));
                endcase
            end
            if (phase == 0) begin
                foreach (script[k]) begin
                    typed_exp        = '0;
                    typed_exp.status = script[k].status;
                    typed_exp.owing  = script[k].owing;
                    push_order(script[k].ord, script[k].typed, typed_exp);
                end
            end
            if (phase == 1) begin
                // The result side holds off while items keep coming.
                hold_rsp = 1'b1;
            end
            while (items_sent < (phase + 1) * PHASE_ITEMS) begin
                random_group();
            end
        end
        drain();

        if (mismatches == 0 && pending_payouts.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
